/* hdl/lcta_pkg.sv */
package lcta_pkg;

    // Converter word geometry and collection limit.
    localparam int unsigned SAMPLE_BITS = 24;
    localparam int unsigned MAX_SAMPLES = 255;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_SAMPLE_COUNT = 3'd0;
    localparam logic [2:0] REG_RAW_ZERO     = 3'd1;
    localparam logic [2:0] REG_RAW_SPAN     = 3'd2;
    localparam logic [2:0] REG_WEIGHT_ZERO  = 3'd3;
    localparam logic [2:0] REG_WEIGHT_SPAN  = 3'd4;

    // Register reset values.
    localparam logic [7:0]  SAMPLE_COUNT_RST = 8'd10;
    localparam logic [23:0] RAW_ZERO_RST     = 24'd0;
    localparam logic [23:0] RAW_SPAN_RST     = 24'd1;
    localparam logic [31:0] WEIGHT_ZERO_RST  = 32'd0;
    localparam logic [31:0] WEIGHT_SPAN_RST  = 32'd1;

    // Extremes of a sign-extended sample, held at 24 bits.
    localparam logic signed [23:0] SAMPLE_MIN = 24'(-(64'sd1 <<< (SAMPLE_BITS - 1)));
    localparam logic signed [23:0] SAMPLE_MAX = 24'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);

    // Saturation limits of the result.
    localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

    // Step counts of the shared unit.
    localparam logic [5:0] MUL_STEPS      = 6'd25;
    localparam logic [5:0] CAL_DIV_STEPS  = 6'd58;
    localparam logic [5:0] MEAN_DIV_STEPS = 6'd32;

    typedef struct packed {
        logic       start;
        logic       div;
        logic [5:0] steps;
    } t_mdu_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_mdu_sts;

    typedef struct packed {
        logic signed [31:0] sum;
        logic signed [23:0] largest;
        logic signed [23:0] smallest;
        logic [7:0]         seen;
    } t_coll;

    // Keep the low SAMPLE_BITS bits of the word and sign-extend them.
    function automatic logic signed [23:0] sext_sample(input logic [23:0] w);
        logic signed [23:0] t;
        t = $signed(w << (24 - SAMPLE_BITS));
        return t >>> (24 - SAMPLE_BITS);
    endfunction

endpackage

/* hdl/lcta_ifs.sv */
interface lcta_sample_if;
    logic        valid;
    logic        ready;
    logic [23:0] raw_word;
    modport source (output valid, output raw_word, input ready);
    modport sink (input valid, input raw_word, output ready);
endinterface

interface lcta_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] value;
    logic        calibrated;
    logic        span_error;
    modport source (output valid, output value, output calibrated, output span_error,
                    input ready);
    modport sink (input valid, input value, input calibrated, input span_error,
                  output ready);
endinterface

interface lcta_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* hdl/load_cell_trimmed_average_top.sv */
// Calibrated mode: a 25-step shift-and-add multiply and a 58-step restoring divide on one adder;
// equal calibration points skip both and give a zero value with span_error set. Trimmed mode:
// a sample short of a full set only joins the collection; the last one runs the 32-step divide.
// No new sample is taken while a result is being worked out or waits to enter the output register.
// Ready needs an idle sequencer and no offered write; a finished result waits for a free output.
// Reset is synchronous, active low; it loads the register defaults and clears the collection.
module load_cell_trimmed_average_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lcta_sample_if.sink    i_sample,
    lcta_cfg_if.sink       i_cfg,
    lcta_result_if.source  o_result
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CPREP = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DLOAD = 4'd3;
    localparam logic [3:0] S_TPREP = 4'd4;
    localparam logic [3:0] S_TLOAD = 4'd5;
    localparam logic [3:0] S_DIV   = 4'd6;
    localparam logic [3:0] S_SIGN  = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    logic [3:0]  r_state;
    logic [3:0]  n_state;

    logic [7:0]  r_sample_count;
    logic [23:0] r_raw_zero;
    logic [23:0] r_raw_span;
    logic [31:0] r_weight_zero;
    logic [31:0] r_weight_span;

    logic [24:0] r_a;
    logic [32:0] r_b;
    logic [24:0] r_d;
    logic [24:0] r_dmag;
    logic [33:0] r_t;
    logic [7:0]  r_cnt;
    logic        r_neg;
    logic        r_cal;
    logic        r_err;
    logic [59:0] r_qs;

    logic        r_ov;
    logic [31:0] r_oval;
    logic        r_ocal;
    logic        r_oerr;

    lcta_pkg::t_mdu_ctl w_ctl;
    lcta_pkg::t_mdu_sts w_sts;
    lcta_pkg::t_coll    w_coll;
    logic [57:0]        w_load;
    logic [32:0]        w_opnd;
    logic [57:0]        w_prod;
    logic [57:0]        w_quot;

    logic signed [23:0] w_x;
    logic [7:0]         w_n;
    logic               w_single;
    logic               w_accept;
    logic               w_last;
    logic               w_out_free;
    logic [24:0]        w_amag;
    logic [32:0]        w_bmag;
    logic [24:0]        w_dmag;
    logic [33:0]        w_tmag;
    logic [59:0]        w_mag;
    logic [59:0]        w_cal_sum;
    logic [31:0]        w_res;

    // Configuration registers; writes are only made while idle.
    assign i_cfg.ready = r_state == S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_count <= lcta_pkg::SAMPLE_COUNT_RST;
            r_raw_zero     <= lcta_pkg::RAW_ZERO_RST;
            r_raw_span     <= lcta_pkg::RAW_SPAN_RST;
            r_weight_zero  <= lcta_pkg::WEIGHT_ZERO_RST;
            r_weight_span  <= lcta_pkg::WEIGHT_SPAN_RST;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                lcta_pkg::REG_SAMPLE_COUNT: r_sample_count <= i_cfg.data[7:0];
                lcta_pkg::REG_RAW_ZERO:     r_raw_zero     <= i_cfg.data[23:0];
                lcta_pkg::REG_RAW_SPAN:     r_raw_span     <= i_cfg.data[23:0];
                lcta_pkg::REG_WEIGHT_ZERO:  r_weight_zero  <= i_cfg.data;
                lcta_pkg::REG_WEIGHT_SPAN:  r_weight_span  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    assign w_x      = lcta_pkg::sext_sample(i_sample.raw_word);
    assign w_n      = (16'(r_sample_count) > 16'(lcta_pkg::MAX_SAMPLES))
                      ? 8'(lcta_pkg::MAX_SAMPLES) : r_sample_count;
    assign w_single = w_n <= 8'd2;
    // A register write offered while idle goes first; the sample waits until no write is offered.
    assign i_sample.ready = (r_state == S_IDLE) && !i_cfg.valid;
    assign w_accept = i_sample.valid && i_sample.ready;
    assign w_last   = ({1'b0, w_coll.seen} + 9'd1) >= {1'b0, w_n};
    assign w_out_free = !r_ov || o_result.ready;

    lcta_coll u_coll (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (w_accept && !w_single),
        .i_clr    (r_state == S_TPREP),
        .i_sample (w_x),
        .o_coll   (w_coll)
    );

    // Magnitudes for the unsigned shared unit; signs are tracked apart.
    assign w_amag = r_a[24] ? (~r_a + 25'd1) : r_a;
    assign w_bmag = r_b[32] ? (~r_b + 33'd1) : r_b;
    assign w_dmag = r_d[24] ? (~r_d + 25'd1) : r_d;
    assign w_tmag = r_t[33] ? (~r_t + 34'd1) : r_t;

    always_comb begin
        w_ctl.start = 1'b0;
        w_ctl.div   = 1'b1;
        w_ctl.steps = lcta_pkg::CAL_DIV_STEPS;
        w_load      = w_prod;
        w_opnd      = {8'd0, r_dmag};
        unique case (r_state)
            S_CPREP: begin
                w_ctl.start = r_d != 25'd0;
                w_ctl.div   = 1'b0;
                w_ctl.steps = lcta_pkg::MUL_STEPS;
                w_load      = {33'd0, w_amag};
                w_opnd      = w_bmag;
            end
            S_DLOAD: begin
                w_ctl.start = 1'b1;
            end
            S_TLOAD: begin
                w_ctl.start = 1'b1;
                w_ctl.steps = lcta_pkg::MEAN_DIV_STEPS;
                // Left-aligned so that 32 steps leave the quotient in the low bits.
                w_load      = {w_tmag[31:0], 26'd0};
                w_opnd      = {25'd0, r_cnt};
            end
            default: begin
            end
        endcase
    end

    lcta_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_load  (w_load),
        .i_opnd  (w_opnd),
        .o_sts   (w_sts),
        .o_prod  (w_prod),
        .o_quot  (w_quot)
    );

    assign w_mag     = r_cal ? {2'd0, w_quot} : {28'd0, w_quot[31:0]};
    assign w_cal_sum = r_qs + {{28{r_weight_zero[31]}}, r_weight_zero};

    always_comb begin
        if (r_err) begin
            w_res = 32'd0;
        end else if (!r_cal) begin
            w_res = r_qs[31:0];
        end else if ((&w_cal_sum[59:31]) || !(|w_cal_sum[59:31])) begin
            w_res = w_cal_sum[31:0];
        end else begin
            w_res = w_cal_sum[59] ? lcta_pkg::VALUE_MIN : lcta_pkg::VALUE_MAX;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && w_single) begin
                    n_state = S_CPREP;
                end else if (w_accept && w_last) begin
                    n_state = S_TPREP;
                end
            end
            S_CPREP: n_state = (r_d == 25'd0) ? S_FIN : S_MUL;
            S_MUL:   n_state = w_sts.done ? S_DLOAD : S_MUL;
            S_DLOAD: n_state = S_DIV;
            S_TPREP: n_state = S_TLOAD;
            S_TLOAD: n_state = S_DIV;
            S_DIV:   n_state = w_sts.done ? S_SIGN : S_DIV;
            S_SIGN:  n_state = S_FIN;
            S_FIN:   n_state = w_out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_a   <= {w_x[23], w_x} - {r_raw_zero[23], r_raw_zero};
                r_b   <= {r_weight_span[31], r_weight_span}
                         - {r_weight_zero[31], r_weight_zero};
                r_d   <= {r_raw_span[23], r_raw_span} - {r_raw_zero[23], r_raw_zero};
                r_cal <= w_single;
                r_err <= 1'b0;
            end
            S_CPREP: begin
                r_err  <= r_d == 25'd0;
                r_neg  <= r_a[24] ^ r_b[32] ^ r_d[24];
                r_dmag <= w_dmag;
            end
            S_TPREP: begin
                r_t   <= 34'(w_coll.sum) - 34'(w_coll.largest) - 34'(w_coll.smallest);
                r_cnt <= w_coll.seen - 8'd2;
            end
            S_TLOAD: begin
                r_neg <= r_t[33];
            end
            S_SIGN: begin
                r_qs <= r_neg ? (~w_mag + 60'd1) : w_mag;
            end
            default: begin
            end
        endcase
    end

    // Output register; a finished result waits here until the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_FIN && w_out_free) begin
            r_ov <= 1'b1;
        end else if (o_result.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN && w_out_free) begin
            r_oval <= w_res;
            r_ocal <= r_cal;
            r_oerr <= r_err;
        end
    end

    assign o_result.valid      = r_ov;
    assign o_result.value      = r_oval;
    assign o_result.calibrated = r_ocal;
    assign o_result.span_error = r_oerr;

    a_ready_unit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_sample.ready |-> !w_sts.busy)
        else $error("sample taken while the shared unit is busy");

    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sts.done |-> (r_state == S_MUL || r_state == S_DIV))
        else $error("shared unit finished outside a waiting state");

    a_clear_after_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_TPREP |=> w_coll.seen == 8'd0)
        else $error("collection not cleared after the last sample of a set");

    a_single_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_single) |=> r_state == S_CPREP)
        else $error("calibrated sample did not start the calibration sequence");

endmodule

/* hdl/lcta_mdu.sv */
module lcta_mdu (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lcta_pkg::t_mdu_ctl  i_ctl,
    input  logic [57:0]         i_load,
    input  logic [32:0]         i_opnd,
    output lcta_pkg::t_mdu_sts  o_sts,
    output logic [57:0]         o_prod,
    output logic [57:0]         o_quot
);

    logic        r_busy;
    logic        r_done;
    logic        r_div;
    logic [5:0]  r_cnt;
    logic [33:0] r_acc;
    logic [57:0] r_shf;
    logic [32:0] r_opnd;

    logic [34:0] w_a;
    logic [34:0] w_b;
    logic [34:0] w_sum;
    logic        w_qbit;
    logic [33:0] n_acc;
    logic [57:0] n_shf;

    // One adder serves both operations: add for shift-and-add multiply,
    // subtract for the restoring divide.
    always_comb begin
        if (r_div) begin
            w_a = {9'd0, r_acc[24:0], r_shf[57]};
            w_b = {2'd0, r_opnd};
        end else begin
            w_a = {1'b0, r_acc};
            w_b = r_shf[0] ? {2'd0, r_opnd} : 35'd0;
        end
        w_sum  = w_a + (r_div ? ~w_b : w_b) + {34'd0, r_div};
        w_qbit = ~w_sum[34];
        if (r_div) begin
            n_acc = w_qbit ? {9'd0, w_sum[24:0]} : {9'd0, w_a[24:0]};
            n_shf = {r_shf[56:0], w_qbit};
        end else begin
            n_acc = w_sum[34:1];
            n_shf = {w_sum[0], r_shf[57:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == 6'd0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_div  <= i_ctl.div;
            r_cnt  <= i_ctl.steps - 6'd1;
            r_acc  <= 34'd0;
            r_shf  <= i_load;
            r_opnd <= i_opnd;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            r_acc <= n_acc;
            r_shf <= n_shf;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_prod     = {r_acc[32:0], r_shf[57:33]};
    assign o_quot     = r_shf;

endmodule

/* hdl/lcta_coll.sv */
module lcta_coll (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_upd,
    input  logic               i_clr,
    input  logic signed [23:0] i_sample,
    output lcta_pkg::t_coll    o_coll
);

    lcta_pkg::t_coll r_coll;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_coll.sum      <= 32'sd0;
            r_coll.largest  <= lcta_pkg::SAMPLE_MIN;
            r_coll.smallest <= lcta_pkg::SAMPLE_MAX;
            r_coll.seen     <= 8'd0;
        end else if (i_upd) begin
            r_coll.sum  <= r_coll.sum + 32'(i_sample);
            r_coll.seen <= r_coll.seen + 8'd1;
            if (i_sample > r_coll.largest) begin
                r_coll.largest <= i_sample;
            end
            if (i_sample < r_coll.smallest) begin
                r_coll.smallest <= i_sample;
            end
        end
    end

    assign o_coll = r_coll;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int SETTLE_CYCLES = 120;
    localparam int STALL_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 400;
    localparam longint VALUE_HI  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint VALUE_LO  = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        logic [31:0] value;
        logic        calibrated;
        logic        span_error;
    } t_reading;

    logic i_clk;
    logic i_rst_n;

    lcta_sample_if sample_bus ();
    lcta_cfg_if    cfg_bus ();
    lcta_result_if result_bus ();

    load_cell_trimmed_average_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_bus),
        .i_cfg    (cfg_bus),
        .o_result (result_bus)
    );

    // Our own copy of the registers and of the running collection.
    logic [7:0] set_count;
    longint     cal_raw_zero;
    longint     cal_raw_span;
    longint     cal_weight_zero;
    longint     cal_weight_span;
    longint     coll_sum;
    longint     coll_largest;
    longint     coll_smallest;
    logic [7:0] coll_seen;

    t_reading pending_readings[$];
    int       errors = 0;
    int       samples_sent = 0;
    bit       steady = 1'b0;
    int       hold_request = 0;

    initial begin : clock_gen
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic void clear_collection();
        coll_sum      = 0;
        coll_largest  = longint'(lcta_pkg::SAMPLE_MIN);
        coll_smallest = longint'(lcta_pkg::SAMPLE_MAX);
        coll_seen     = '0;
    endfunction

    function automatic void load_defaults();
        set_count       = lcta_pkg::SAMPLE_COUNT_RST;
        cal_raw_zero    = longint'($signed(lcta_pkg::RAW_ZERO_RST));
        cal_raw_span    = longint'($signed(lcta_pkg::RAW_SPAN_RST));
        cal_weight_zero = longint'($signed(lcta_pkg::WEIGHT_ZERO_RST));
        cal_weight_span = longint'($signed(lcta_pkg::WEIGHT_SPAN_RST));
        clear_collection();
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            lcta_pkg::REG_SAMPLE_COUNT: set_count       = data[7:0];
            lcta_pkg::REG_RAW_ZERO:     cal_raw_zero    = longint'($signed(data[23:0]));
            lcta_pkg::REG_RAW_SPAN:     cal_raw_span    = longint'($signed(data[23:0]));
            lcta_pkg::REG_WEIGHT_ZERO:  cal_weight_zero = longint'($signed(data));
            lcta_pkg::REG_WEIGHT_SPAN:  cal_weight_span = longint'($signed(data));
            default: ;
        endcase
    endfunction

    // Works out what one accepted sample yields and queues it, if anything.
    function automatic void weigh_sample(logic [23:0] word);
        longint      x;
        longint      den;
        longint      num;
        longint      r;
        longint      divisor;
        int unsigned eff_count;
        t_reading    rd;
        x = longint'($signed(word << (24 - lcta_pkg::SAMPLE_BITS)))
            >>> (24 - lcta_pkg::SAMPLE_BITS);
        eff_count = (set_count > lcta_pkg::MAX_SAMPLES) ? lcta_pkg::MAX_SAMPLES : set_count;
        if (eff_count <= 2) begin
            rd.calibrated = 1'b1;
            den = cal_raw_span - cal_raw_zero;
            if (den == 0) begin
                rd.value      = '0;
                rd.span_error = 1'b1;
            end else begin
                num = (x - cal_raw_zero) * (cal_weight_span - cal_weight_zero);
                r = num / den + cal_weight_zero;
                if (r > VALUE_HI) r = VALUE_HI;
                if (r < VALUE_LO) r = VALUE_LO;
                rd.value      = r[31:0];
                rd.span_error = 1'b0;
            end
            pending_readings.push_back(rd);
            return;
        end
        // Single-mode samples above never touch the collection.
        coll_sum += x;
        if (x > coll_largest) coll_largest = x;
        if (x < coll_smallest) coll_smallest = x;
        coll_seen = coll_seen + 8'd1;
        if (coll_seen < eff_count) return;
        // The divisor follows the samples actually gathered, not the register.
        divisor = longint'(coll_seen) - 2;
        if (divisor < 1) divisor = 1;
        r = (coll_sum - coll_largest - coll_smallest) / divisor;
        rd.value      = r[31:0];
        rd.calibrated = 1'b0;
        rd.span_error = 1'b0;
        pending_readings.push_back(rd);
        clear_collection();
    endfunction

    function automatic int idle_length();
        int pick;
        if (steady) return 0;
        pick = $urandom_range(99);
        if (pick < 55) return 0;
        if (pick < 85) return $urandom_range(3, 1);
        if (pick < 97) return $urandom_range(15, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic logic [23:0] pick_word();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4) return 24'h80_0000;
        if (pick < 8) return 24'h7F_FFFF;
        if (pick < 10) return 24'hFF_FFFF;
        if (pick < 30) return 24'($urandom_range(4000)) - 24'd2000;
        return 24'($urandom);
    endfunction

    function automatic logic [31:0] pick_weight();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10) return 32'h8000_0000;
        if (pick < 20) return 32'h7FFF_FFFF;
        if (pick < 50) return 32'($urandom_range(200000)) - 32'd100000;
        return $urandom;
    endfunction

    initial begin : result_receiver
        int idle_left;
        int hold_left;
        idle_left = 0;
        hold_left = 0;
        result_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_bus.ready = 1'b0;
            end else if (idle_left > 0) begin
                idle_left--;
                result_bus.ready = 1'b0;
            end else begin
                result_bus.ready = 1'b1;
                idle_left = idle_length();
            end
        end
    end

    always @(posedge i_clk) begin : reading_checker
        t_reading want;
        if (i_rst_n && result_bus.valid && result_bus.ready) begin
            if (pending_readings.size() == 0) begin
                $error("result beat with nothing expected: value %0d",
                       $signed(result_bus.value));
                errors++;
            end else begin
                want = pending_readings.pop_front();
                if (result_bus.value !== want.value) begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(result_bus.value));
                    errors++;
                end
                if (result_bus.calibrated !== want.calibrated) begin
                    $error("calibrated: expected %0b, got %0b",
                           want.calibrated, result_bus.calibrated);
                    errors++;
                end
                if (result_bus.span_error !== want.span_error) begin
                    $error("span_error: expected %0b, got %0b",
                           want.span_error, result_bus.span_error);
                    errors++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((sample_bus.valid && sample_bus.ready) || (cfg_bus.valid && cfg_bus.ready)
                    || (result_bus.valid && result_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic send_sample(logic [23:0] word);
        int gap;
        gap = idle_length();
        @(negedge i_clk);
        if (gap > 0) begin
            sample_bus.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        sample_bus.valid    = 1'b1;
        sample_bus.raw_word = word;
        do begin
            @(posedge i_clk);
        end while (sample_bus.ready !== 1'b1);
        weigh_sample(word);
        samples_sent++;
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b1;
        cfg_bus.index = idx;
        cfg_bus.data  = data;
        do begin
            @(posedge i_clk);
        end while (cfg_bus.ready !== 1'b1);
        apply_reg(idx, data);
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    // A sample that completes nothing may still be in flight, hence the extra cycles.
    task automatic wait_idle();
        @(negedge i_clk);
        sample_bus.valid = 1'b0;
        while (pending_readings.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic test_power_on_mean();
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h00_0000);
        send_sample(24'hFF_FFFF);
        send_sample(24'h00_0001);
        send_sample(24'h7F_FFFE);
        send_sample(24'h80_0001);
        send_sample(24'h12_3456);
        send_sample(24'hAB_CDEF);
        send_sample(24'h55_5555);
        wait_idle();
    endtask

    task automatic test_calibration_edges();
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd0);
        write_reg(lcta_pkg::REG_RAW_ZERO, 32'd0);
        write_reg(lcta_pkg::REG_RAW_SPAN, 32'd1);
        write_reg(lcta_pkg::REG_WEIGHT_ZERO, 32'd0);
        write_reg(lcta_pkg::REG_WEIGHT_SPAN, 32'd1);
        send_sample(24'h80_0000);
        send_sample(24'h7F_FFFF);
        send_sample(24'h00_0001);
        wait_idle();
        // Full-scale gain pushes the result past both saturation limits.
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd2);
        write_reg(lcta_pkg::REG_WEIGHT_SPAN, 32'h7FFF_FFFF);
        send_sample(24'h7F_FFFF);
        send_sample(24'h80_0000);
        wait_idle();
        write_reg(lcta_pkg::REG_RAW_SPAN, 32'd0);
        send_sample(24'h12_3456);
        wait_idle();
    endtask

    task automatic test_collection_interrupted();
        write_reg(lcta_pkg::REG_RAW_SPAN, 32'd1000);
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd10);
        send_sample(24'h00_0100);
        send_sample(24'hFF_FF00);
        send_sample(24'h7F_0000);
        send_sample(24'h80_1234);
        wait_idle();
        // A single calibrated sample must leave the partial set alone.
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd1);
        send_sample(24'h00_0042);
        wait_idle();
        // Lowering the count below what is held closes the set on the next sample.
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd3);
        send_sample(24'h00_0777);
        wait_idle();
    endtask

    task automatic test_full_set();
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, {24'($urandom), 8'd255});
        repeat (255) send_sample(pick_word());
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        write_reg(lcta_pkg::REG_SAMPLE_COUNT, 32'd3);
        steady = 1'b1;
        @(posedge i_clk);
        hold_request = HOLD_CYCLES;
        repeat (30) send_sample(pick_word());
        steady = 1'b0;
        wait_idle();
    endtask

    task automatic test_random_phases(int target);
        int          stop_at;
        int          items;
        int          span;
        logic [23:0] zero_point;
        stop_at = samples_sent + target;
        while (samples_sent < stop_at) begin
            steady = ($urandom_range(3) == 0);
            if ($urandom_range(9) < 6) begin
                span = ($urandom_range(4) == 0) ? $urandom_range(40, 3) : $urandom_range(8, 3);
                write_reg(lcta_pkg::REG_SAMPLE_COUNT, {24'($urandom), 8'(span)});
                // Often leave a partial set behind for the next phase to finish.
                items = span * $urandom_range(3, 1) + $urandom_range(span - 1);
            end else begin
                write_reg(lcta_pkg::REG_SAMPLE_COUNT, {24'($urandom), 8'($urandom_range(2))});
                zero_point = pick_word();
                write_reg(lcta_pkg::REG_RAW_ZERO, {8'($urandom), zero_point});
                write_reg(lcta_pkg::REG_RAW_SPAN, {8'($urandom),
                          ($urandom_range(11) == 0) ? zero_point : pick_word()});
                write_reg(lcta_pkg::REG_WEIGHT_ZERO, pick_weight());
                write_reg(lcta_pkg::REG_WEIGHT_SPAN, pick_weight());
                items = $urandom_range(25, 5);
            end
            repeat (items) send_sample(pick_word());
            wait_idle();
        end
        steady = 1'b0;
    endtask

    initial begin : test_sequence
        sample_bus.valid    = 1'b0;
        sample_bus.raw_word = '0;
        cfg_bus.valid       = 1'b0;
        cfg_bus.index       = lcta_pkg::REG_SAMPLE_COUNT;
        cfg_bus.data        = '0;
        i_rst_n             = 1'b0;
        load_defaults();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_power_on_mean();
        test_calibration_edges();
        test_collection_interrupted();
        test_full_set();
        test_output_backpressure();
        test_random_phases(440);

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

/* sim.f */
hdl/lcta_pkg.sv
hdl/lcta_ifs.sv
hdl/lcta_mdu.sv
hdl/lcta_coll.sv
hdl/load_cell_trimmed_average_top.sv
tb/tb_top.sv
